// ===== hdl/istl_pkg.sv =====
`timescale 1ns / 1ps
package istl_pkg;

  localparam int NUM_W    = 61;
  localparam int REASON_W = 16;
  localparam int LIMIT_W  = 7;
  localparam int SLOT_W   = 6;
  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
  localparam logic [7:0] MAX_STREAMS_FRAME = 8'h12;

  typedef enum logic [1:0] {
    OP_OPEN    = 2'd0,
    OP_ACCEPT  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_CLOSE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_ABOVE_MAX      = 3'd1,
    ST_NOT_FOUND      = 3'd2,
    ST_DOUBLE_RELEASE = 3'd3,
    ST_NOT_READY      = 3'd4,
    ST_CLOSED         = 3'd5,
    ST_TABLE_FULL     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SPAN,
    S_RD,
    S_CMP,
    S_FREE,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t               status;
    logic                  has_stream;
    logic [SLOT_W-1:0]     slot_index;
    logic [NUM_W-1:0]      returned_number;
    logic [REASON_W-1:0]   error_reason;
    logic                  credit_valid;
    logic [NUM_W-1:0]      credit_max;
  } res_t;

endpackage

// ===== hdl/istl_mem.sv =====
`timescale 1ns / 1ps
module istl_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 61
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/istl_ctrl.sv =====
`timescale 1ns / 1ps
module istl_ctrl #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  istl_pkg::op_t                  in_op,
  input  logic [istl_pkg::NUM_W-1:0]     in_num,
  input  logic [istl_pkg::REASON_W-1:0]  in_reason,
  input  logic                           cfg_we,
  input  logic [istl_pkg::LIMIT_W-1:0]   cfg_limit,
  output logic                           res_valid,
  input  logic                           res_ready,
  output istl_pkg::res_t                 res
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int LW = (CW > istl_pkg::LIMIT_W) ? CW : istl_pkg::LIMIT_W;
  localparam int NW = istl_pkg::NUM_W;

  istl_pkg::state_t state, state_next;

  istl_pkg::op_t                 op_q;
  logic [NW-1:0]                 num_q;
  logic [istl_pkg::REASON_W-1:0] rsn_q;
  logic [NW-1:0]                 key;
  logic                          old;
  logic [IW-1:0]                 idx;
  logic [IW-1:0]                 free_idx;
  logic                          free_found;
  logic [IW-1:0]                 slot;
  logic [CW-1:0]                 live_count;
  logic [NW-1:0]                 next_to_open;
  logic [NW-1:0]                 next_to_accept;
  logic [NW-1:0]                 current_max;
  logic                          closed_flag;
  logic [istl_pkg::REASON_W-1:0] latched_reason;
  logic [istl_pkg::LIMIT_W-1:0]  stream_limit;
  logic [TABLE_ENTRIES-1:0]      live;
  logic [TABLE_ENTRIES-1:0]      mark;

  logic [NW-1:0] mem_q;
  logic          hit;
  logic          last;
  logic          scan_end;
  logic [IW-1:0] free_sel;
  logic [NW-1:0] span;
  logic [CW-1:0] free_cnt;
  logic [CW-1:0] lc_dec;
  logic [LW-1:0] room;
  logic [NW:0]   credit_sum;
  logic [NW-1:0] credit_new;
  logic          mem_we;

  assign hit        = live[idx] && (mem_q == key);
  assign last       = (idx == IW'(TABLE_ENTRIES - 1));
  assign scan_end   = hit || last;
  assign free_sel   = free_found ? free_idx : idx;
  assign span       = num_q - next_to_open + NW'(1);
  assign free_cnt   = CW'(TABLE_ENTRIES) - live_count;
  assign lc_dec     = (live_count != '0) ? live_count - CW'(1) : live_count;
  assign room       = LW'(stream_limit) - LW'(lc_dec);
  assign credit_sum = {1'b0, next_to_open} + (NW + 1)'(room) - (NW + 1)'(1);
  assign credit_new = credit_sum[NW] ? istl_pkg::NUM_MAX : credit_sum[NW-1:0];
  assign mem_we     = (state == istl_pkg::S_CMP) && scan_end && !hit &&
                      (op_q == istl_pkg::OP_OPEN) && !old;

  istl_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW),
    .DW    (NW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_sel),
    .wdata (key),
    .raddr (idx),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= istl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    case (state)
      istl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = istl_pkg::S_DISP;
      end
      istl_pkg::S_DISP: begin
        case (op_q)
          istl_pkg::OP_OPEN: begin
            if (num_q > current_max) state_next = istl_pkg::S_DONE;
            else if (num_q < next_to_open) state_next = istl_pkg::S_RD;
            else state_next = istl_pkg::S_SPAN;
          end
          istl_pkg::OP_ACCEPT: begin
            state_next = closed_flag ? istl_pkg::S_DONE : istl_pkg::S_RD;
          end
          istl_pkg::OP_RELEASE: state_next = istl_pkg::S_RD;
          default: state_next = istl_pkg::S_DONE;
        endcase
      end
      istl_pkg::S_SPAN: begin
        state_next = (span > NW'(free_cnt)) ? istl_pkg::S_DONE : istl_pkg::S_RD;
      end
      istl_pkg::S_RD: state_next = istl_pkg::S_CMP;
      istl_pkg::S_CMP: begin
        if (!scan_end) begin
          state_next = istl_pkg::S_RD;
        end else begin
          case (op_q)
            istl_pkg::OP_OPEN: begin
              state_next = (old || key == num_q) ? istl_pkg::S_DONE : istl_pkg::S_RD;
            end
            istl_pkg::OP_ACCEPT: begin
              state_next = (hit && mark[idx]) ? istl_pkg::S_FREE : istl_pkg::S_DONE;
            end
            istl_pkg::OP_RELEASE: begin
              state_next = (hit && num_q < next_to_accept) ? istl_pkg::S_FREE
                                                           : istl_pkg::S_DONE;
            end
            default: state_next = istl_pkg::S_DONE;
          endcase
        end
      end
      istl_pkg::S_FREE: state_next = istl_pkg::S_DONE;
      istl_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = istl_pkg::S_IDLE;
      end
      default: state_next = istl_pkg::S_IDLE;
    endcase
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      istl_pkg::S_IDLE: begin
        if (in_valid) begin
          op_q  <= in_op;
          num_q <= in_num;
          rsn_q <= in_reason;
          res   <= '0;
        end
      end
      istl_pkg::S_DISP: begin
        idx <= '0;
        case (op_q)
          istl_pkg::OP_OPEN: begin
            if (num_q > current_max) begin
              res.status <= istl_pkg::ST_ABOVE_MAX;
            end else if (num_q < next_to_open) begin
              old <= 1'b1;
              key <= num_q;
            end else begin
              old <= 1'b0;
              key <= next_to_open;
            end
          end
          istl_pkg::OP_ACCEPT: begin
            key <= next_to_accept;
            if (closed_flag) begin
              res.status       <= istl_pkg::ST_CLOSED;
              res.error_reason <= latched_reason;
            end
          end
          istl_pkg::OP_RELEASE: key <= num_q;
          default: res.status <= istl_pkg::ST_OK;
        endcase
      end
      istl_pkg::S_SPAN: begin
        if (span > NW'(free_cnt)) res.status <= istl_pkg::ST_TABLE_FULL;
      end
      istl_pkg::S_CMP: begin
        if (!hit && !live[idx] && !free_found) free_idx <= idx;
        if (!scan_end) begin
          idx <= idx + IW'(1);
        end else begin
          slot <= idx;
          case (op_q)
            istl_pkg::OP_OPEN: begin
              if (old) begin
                res.status <= istl_pkg::ST_OK;
                if (hit && !mark[idx]) begin
                  res.has_stream      <= 1'b1;
                  res.slot_index      <= istl_pkg::SLOT_W'(idx);
                  res.returned_number <= num_q;
                end
              end else if (key == num_q) begin
                res.status          <= istl_pkg::ST_OK;
                res.has_stream      <= 1'b1;
                res.slot_index      <= istl_pkg::SLOT_W'(hit ? idx : free_sel);
                res.returned_number <= num_q;
              end else begin
                key <= key + NW'(1);
                idx <= '0;
              end
            end
            istl_pkg::OP_ACCEPT: begin
              if (!hit) begin
                res.status <= istl_pkg::ST_NOT_READY;
              end else begin
                res.status          <= istl_pkg::ST_OK;
                res.has_stream      <= 1'b1;
                res.slot_index      <= istl_pkg::SLOT_W'(idx);
                res.returned_number <= key;
              end
            end
            istl_pkg::OP_RELEASE: begin
              if (!hit) res.status <= istl_pkg::ST_NOT_FOUND;
              else if (num_q >= next_to_accept && mark[idx])
                res.status <= istl_pkg::ST_DOUBLE_RELEASE;
              else res.status <= istl_pkg::ST_OK;
            end
            default: res.status <= istl_pkg::ST_OK;
          endcase
        end
      end
      istl_pkg::S_FREE: begin
        if (LW'(stream_limit) > LW'(lc_dec)) begin
          res.credit_valid <= 1'b1;
          res.credit_max   <= credit_new;
        end
      end
      default: ;
    endcase
  end

  // control and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      free_found     <= 1'b0;
      live_count     <= '0;
      next_to_open   <= NW'(1);
      next_to_accept <= NW'(1);
      current_max    <= '0;
      closed_flag    <= 1'b0;
      latched_reason <= '0;
      stream_limit   <= '0;
      live           <= '0;
      mark           <= '0;
    end else begin
      if (cfg_we) begin
        stream_limit <= cfg_limit;
        current_max  <= NW'(cfg_limit);
      end
      case (state)
        istl_pkg::S_DISP: begin
          free_found <= 1'b0;
          if (op_q == istl_pkg::OP_CLOSE) begin
            closed_flag    <= 1'b1;
            latched_reason <= rsn_q;
          end
        end
        istl_pkg::S_CMP: begin
          if (scan_end && op_q == istl_pkg::OP_OPEN && !old) begin
            free_found <= 1'b0;
          end else if (!hit && !live[idx]) begin
            free_found <= 1'b1;
          end
          if (scan_end) begin
            case (op_q)
              istl_pkg::OP_OPEN: begin
                if (!old) begin
                  if (!hit) begin
                    live[free_sel] <= 1'b1;
                    mark[free_sel] <= 1'b0;
                    live_count     <= live_count + CW'(1);
                  end
                  if (key == num_q) next_to_open <= num_q + NW'(1);
                end
              end
              istl_pkg::OP_ACCEPT: begin
                if (hit) next_to_accept <= next_to_accept + NW'(1);
              end
              istl_pkg::OP_RELEASE: begin
                if (hit && num_q >= next_to_accept) mark[idx] <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        istl_pkg::S_FREE: begin
          live[slot] <= 1'b0;
          mark[slot] <= 1'b0;
          live_count <= lc_dec;
          if (LW'(stream_limit) > LW'(lc_dec)) current_max <= credit_new;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/incoming_stream_limit_tracker.sv =====
`timescale 1ns / 1ps
// Close, above-max opens and accepts after close give their result without a table scan;
// table-full opens stop after the span check; reopens, accepts and releases scan the table
// (with a further step when a slot is freed); an open of a new range scans once per number.
// Throughput: one request at a time; the next is taken the cycle after the result moves
// to the output register. Each table scan reads one entry at a time, in S_RD then S_CMP.
// Reset (rst, synchronous): table empty at once through live bits, open/accept counters at one.
module incoming_stream_limit_tracker #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // stream_number, close_reason, zero pad
  input  logic [1:0]   s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // has_stream, slot_index, returned_number, error_reason, credit_valid,
  // credit_max, zero pad
  output logic [151:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,  // status
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  istl_pkg::res_t res;
  istl_pkg::res_t out_q;
  logic           res_valid;
  logic           res_ready;

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  istl_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (istl_pkg::op_t'(s_axis_tuser)),
    .in_num    (s_axis_tdata[60:0]),
    .in_reason (s_axis_tdata[76:61]),
    .cfg_we    (cfg_we),
    .cfg_limit (cfg_wdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tuser = out_q.status;
  assign m_axis_tdata = {6'd0, out_q.credit_max, out_q.credit_valid, out_q.error_reason,
                         out_q.returned_number, out_q.slot_index, out_q.has_stream};

endmodule
